// File: design/keyed_tally_table_assert.svh
// assertion macros used by the keyed tally table datapath
`ifndef KEYED_TALLY_TABLE_ASSERT_SVH
`define KEYED_TALLY_TABLE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define KTT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyed tally table check failed");

// next-cycle implication, checked out of reset
`define KTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyed tally table check failed");

`endif

// File: design/ktt_pkg.sv
// shared types and constants for the keyed tally table
`timescale 1ns / 1ps
`default_nettype none

package ktt_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 64;
    localparam int TALLY_BITS    = 32;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // fixed result field widths
    localparam int ENTRY_OUT_W = 6;
    localparam int TALLY_OUT_W = 32;
    localparam int TOTAL_OUT_W = 7;

    // one request: six particle counts
    typedef struct packed {
        logic [3:0] pi_plus_count;
        logic [3:0] pi_minus_count;
        logic [3:0] pi_zero_count;
        logic [3:0] gamma_count;
        logic [3:0] proton_count;
        logic [3:0] neutron_count;
    } req_t;

    localparam int KEY_W = $bits(req_t);

    // one result
    typedef struct packed {
        logic [ENTRY_OUT_W-1:0] entry_index;
        logic [TALLY_OUT_W-1:0] tally_now;
        logic                   was_hit;
        logic                   was_dropped;
        logic [TOTAL_OUT_W-1:0] distinct_total;
    } result_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HIT,
        ST_MISS
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic fin_hit;
        logic fin_miss;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic match;
        logic miss;
    } status_t;

endpackage

`default_nettype wire

// File: design/ktt_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module ktt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_W-1:0]    waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic                 re,
    input  wire logic [ADDR_W-1:0]    raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/ktt_ctrl.sv
// controller state machine for the keyed tally table
`timescale 1ns / 1ps
`default_nettype none

module ktt_ctrl import ktt_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire status_t status,
    output logic         busy,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.match)
                begin
                    state_next = ST_HIT;
                end
                else if (status.miss)
                begin
                    state_next = ST_MISS;
                end
            end
            ST_HIT:  state_next = ST_IDLE;
            ST_MISS: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_SCAN: cmd.scan     = 1'b1;
            ST_HIT:  cmd.fin_hit  = 1'b1;
            ST_MISS: cmd.fin_miss = 1'b1;
            default: busy = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// File: design/ktt_dpath.sv
// datapath for the keyed tally table: stores, scan pipeline and result register
`timescale 1ns / 1ps
`default_nettype none

`include "keyed_tally_table_assert.svh"

module ktt_dpath import ktt_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cmd_t    cmd,
    input  wire req_t    req,
    output status_t      status,
    output logic         done,
    output result_t      result
);

    req_t                  key_reg;
    logic [CNT_W-1:0]      used_reg;
    logic [CNT_W-1:0]      used_next;
    logic [CNT_W-1:0]      rd_cnt_reg;
    logic                  pend_valid_reg;
    logic [IDX_W-1:0]      pend_idx_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [TALLY_BITS-1:0] hit_tally_reg;
    logic                  done_reg;
    result_t               result_reg;
    result_t               result_next;

    logic                  issue;
    logic                  full;
    logic [KEY_W-1:0]      key_rdata;
    logic [TALLY_BITS-1:0] tally_rdata;
    logic [TALLY_BITS-1:0] tally_inc;
    logic                  key_we;
    logic                  tally_we;
    logic [IDX_W-1:0]      tally_waddr;
    logic [TALLY_BITS-1:0] tally_wdata;

    // scan control
    assign issue = cmd.scan && (rd_cnt_reg != used_reg);
    assign full  = (used_reg == CNT_W'(TABLE_ENTRIES));

    assign status.match = pend_valid_reg && (key_rdata == key_reg);
    assign status.miss  = !pend_valid_reg && (rd_cnt_reg == used_reg);

    // saturating increment of the matched tally
    assign tally_inc = (hit_tally_reg == {TALLY_BITS{1'b1}}) ?
                       hit_tally_reg : hit_tally_reg + TALLY_BITS'(1);

    // store write ports
    assign key_we      = cmd.fin_miss && !full;
    assign tally_we    = cmd.fin_hit || key_we;
    assign tally_waddr = cmd.fin_hit ? hit_idx_reg : used_reg[IDX_W-1:0];
    assign tally_wdata = cmd.fin_hit ? tally_inc : TALLY_BITS'(1);

    ktt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (used_reg[IDX_W-1:0]),
        .wdata (key_reg),
        .re    (issue),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (key_rdata)
    );

    ktt_ram #(
        .WIDTH (TALLY_BITS),
        .DEPTH (TABLE_ENTRIES)
    ) u_tally_ram (
        .clk   (clk),
        .we    (tally_we),
        .waddr (tally_waddr),
        .wdata (tally_wdata),
        .re    (issue),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (tally_rdata)
    );

    // entry count after this request
    always_comb
    begin
        used_next = used_reg;
        if (key_we)
        begin
            used_next = used_reg + CNT_W'(1);
        end
    end

    // result assembly
    always_comb
    begin
        result_next = '0;
        if (cmd.fin_hit)
        begin
            result_next.entry_index    = ENTRY_OUT_W'(hit_idx_reg);
            result_next.tally_now      = TALLY_OUT_W'(tally_inc);
            result_next.was_hit        = 1'b1;
            result_next.distinct_total = TOTAL_OUT_W'(used_reg);
        end
        else if (key_we)
        begin
            result_next.entry_index    = ENTRY_OUT_W'(used_reg[IDX_W-1:0]);
            result_next.tally_now      = TALLY_OUT_W'(1);
            result_next.distinct_total = TOTAL_OUT_W'(used_next);
        end
        else
        begin
            result_next.was_dropped    = 1'b1;
            result_next.distinct_total = TOTAL_OUT_W'(used_reg);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            rd_cnt_reg     <= '0;
            pend_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            done_reg <= cmd.fin_hit || cmd.fin_miss;
            if (cmd.load)
            begin
                rd_cnt_reg     <= '0;
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                pend_valid_reg <= issue;
                if (issue)
                begin
                    rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= req;
        end
        if (issue)
        begin
            pend_idx_reg <= rd_cnt_reg[IDX_W-1:0];
        end
        if (cmd.scan && status.match)
        begin
            hit_idx_reg   <= pend_idx_reg;
            hit_tally_reg <= tally_rdata;
        end
        if (cmd.fin_hit || cmd.fin_miss)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // checks
    `KTT_ASSERT_IMPL(a_used_bound, clk, rst_n, 1'b1, used_reg <= CNT_W'(TABLE_ENTRIES))
    `KTT_ASSERT_IMPL(a_scan_bound, clk, rst_n, 1'b1, rd_cnt_reg <= used_reg)
    `KTT_ASSERT_NEXT(a_append_grows, clk, rst_n, key_we, used_reg == $past(used_reg) + CNT_W'(1))

endmodule

`default_nettype wire

// File: design/keyed_tally_table.sv
// top level of the keyed tally table
//
//  channel   signals            direction  accepted when
//  request   start, req         in         start && !busy
//  result    done, result       out        done (one cycle, cannot be held off)
//
// a request is scanned against the filled entries one per cycle through the
// read port of the key and tally rams; busy stays high through the scan, which
// stops at the matching slot on a hit and covers every filled entry on a miss
// or drop, and through the final hit or miss state; done rises the cycle after it.
// reset clears the entry count and the controller; the stores need no clearing.
// the result register is separate from the controller, so a new request may be
// taken in the same cycle that the previous result is shown.
`timescale 1ns / 1ps
`default_nettype none

module keyed_tally_table import ktt_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire req_t req,
    output logic      busy,
    output logic      done,
    output result_t   result
);

    cmd_t    cmd;
    status_t status;

    // sequencing
    ktt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    // stores and result
    ktt_dpath u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .req    (req),
        .status (status),
        .done   (done),
        .result (result)
    );

endmodule

`default_nettype wire
